@@ design/qau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and defaults for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF   = 8;
  localparam int LANES               = 4;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    logic             vld;
    logic             is_div;
    logic             dbz;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] big;
  } qau_flags_t;

endpackage

@@ design/qau_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_front
// Products, four-term sums, norm, and divider setup (three register stages).
// ----------------------------------------------------------------------------
module qau_front #(
  parameter int CW = qau_pkg::COMPONENT_WIDTH_DEF,
  parameter int FB = qau_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_in,
  input  qau_pkg::kind_t                kind_in,
  input  logic signed [CW-1:0]          q1 [4],
  input  logic signed [CW-1:0]          q2 [4],
  output qau_pkg::qau_flags_t           flags_out,
  output logic signed [2*CW+1:0]        val_out [4],
  output logic [3*CW+FB+1:0]            rem_out [4],
  output logic [2*CW:0]                 div_out
);
  import qau_pkg::*;

  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;
  localparam int NW = SW + FB;
  localparam int DW = PW + 1;
  localparam int RW = 3 * CW + FB + 2;

  // stage 1
  logic                 vld1_r;
  kind_t                kind1_r;
  logic signed [PW-1:0] p1_r [4][4];
  logic [PW-1:0]        sq1_r [4];
  logic signed [CW:0]   as1_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    kind1_r <= kind_in;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_r[i][j] <= q1[i] * q2[j];
      end
      sq1_r[i] <= q2[i] * q2[i];
      if (kind_in == KIND_SUB) begin
        as1_r[i] <= {q1[i][CW-1], q1[i]} - {q2[i][CW-1], q2[i]};
      end else begin
        as1_r[i] <= {q1[i][CW-1], q1[i]} + {q2[i][CW-1], q2[i]};
      end
    end
  end

  // stage 2
  logic signed [SW-1:0] pe [4][4];
  logic                 vld2_r;
  kind_t                kind2_r;
  logic signed [SW-1:0] m2_r [4];
  logic signed [SW-1:0] n2_r [4];
  logic [DW-1:0]        norm2_r;
  logic signed [CW:0]   as2_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = SW'(p1_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    kind2_r <= kind1_r;
    as2_r   <= as1_r;
    m2_r[0] <= pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
    m2_r[1] <= pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
    m2_r[2] <= pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
    m2_r[3] <= pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
    n2_r[0] <= pe[0][0] + pe[1][1] + pe[2][2] + pe[3][3];
    n2_r[1] <= pe[1][0] - pe[0][1] - pe[3][2] + pe[2][3];
    n2_r[2] <= pe[2][0] + pe[3][1] - pe[0][2] - pe[1][3];
    n2_r[3] <= pe[3][0] - pe[2][1] + pe[1][2] - pe[0][3];
    norm2_r <= DW'(sq1_r[0]) + DW'(sq1_r[1]) + DW'(sq1_r[2]) + DW'(sq1_r[3]);
  end

  // stage 3: magnitude, sign, range check against divisor
  logic signed [NW-1:0] num   [4];
  logic [NW-1:0]        mag   [4];
  logic signed [SW-1:0] val_c [4];
  logic [RW-1:0]        lim;
  logic [3:0]           neg_c;
  logic [3:0]           big_c;
  qau_flags_t           flags_r;
  logic signed [SW-1:0] val_r [4];
  logic [RW-1:0]        rem_r [4];
  logic [DW-1:0]        div_r;

  always_comb begin
    lim = RW'(norm2_r) << CW;
    for (int i = 0; i < 4; i++) begin
      num[i]   = NW'(n2_r[i]) <<< FB;
      neg_c[i] = num[i][NW-1];
      mag[i]   = neg_c[i] ? NW'(-num[i]) : NW'(num[i]);
      big_c[i] = RW'(mag[i]) >= lim;
      val_c[i] = (kind2_r == KIND_MUL) ? (m2_r[i] >>> FB) : SW'(as2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r.vld    <= vld2_r;
      flags_r.is_div <= kind2_r == KIND_DIV;
      flags_r.dbz    <= (kind2_r == KIND_DIV) && (norm2_r == '0);
      flags_r.neg    <= neg_c;
      flags_r.big    <= big_c;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= norm2_r;
    for (int i = 0; i < 4; i++) begin
      val_r[i] <= val_c[i];
      rem_r[i] <= RW'(mag[i]);
    end
  end

  assign flags_out = flags_r;
  assign val_out   = val_r;
  assign rem_out   = rem_r;
  assign div_out   = div_r;

endmodule

@@ design/qau_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_div_cell
// One restoring-division cell: resolves one quotient bit for all four lanes.
// ----------------------------------------------------------------------------
module qau_div_cell #(
  parameter int CW    = qau_pkg::COMPONENT_WIDTH_DEF,
  parameter int FB    = qau_pkg::FRACTION_BITS_DEF,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic [3*CW+FB+1:0]   rem_in  [4],
  input  logic [CW-1:0]        q_in    [4],
  input  logic [2*CW:0]        div_in,
  output logic [3*CW+FB+1:0]   rem_out [4],
  output logic [CW-1:0]        q_out   [4],
  output logic [2*CW:0]        div_out
);
  import qau_pkg::*;

  localparam int RW = 3 * CW + FB + 2;
  localparam int DW = 2 * CW + 1;

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_nxt [4];
  logic [CW-1:0] q_nxt   [4];
  logic [RW-1:0] rem_r   [4];
  logic [CW-1:0] q_r     [4];
  logic [DW-1:0] div_r;

  always_comb begin
    trial = RW'(div_in) << SHIFT;
    for (int i = 0; i < 4; i++) begin
      if (rem_in[i] >= trial) begin
        rem_nxt[i] = rem_in[i] - trial;
        q_nxt[i]   = q_in[i] | (CW'(1) << SHIFT);
      end else begin
        rem_nxt[i] = rem_in[i];
        q_nxt[i]   = q_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    div_r <= div_in;
  end

  assign rem_out = rem_r;
  assign q_out   = q_r;
  assign div_out = div_r;

endmodule

@@ design/quaternion_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_top
// Add, subtract, Hamilton product and left quotient of two Q8.8 quaternions.
//
//   channel  ports                           handshake
//   input    in_kind, in_first_*, in_second_* start high while busy low
//   result   out_real/i/j/k, flags           out_valid one-cycle strobe
//
// One word accepted per cycle while busy is low. Every operation passes through
// the front stages, the chain of divider cells (one quotient bit per cell) and
// the output register before its result appears.
// busy is high during reset and stays high until a clock edge with rst_n high
// clears it. The receiver cannot stall; nothing is held.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_top #(
  parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = qau_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_real,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_i,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_j,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_k,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_real,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_i,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_j,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_k,
  output logic                              out_valid,
  output logic signed [COMPONENT_WIDTH-1:0] out_real,
  output logic signed [COMPONENT_WIDTH-1:0] out_i,
  output logic signed [COMPONENT_WIDTH-1:0] out_j,
  output logic signed [COMPONENT_WIDTH-1:0] out_k,
  output logic                              out_overflow,
  output logic                              out_divide_by_zero
);
  import qau_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int SW = 2 * CW + 2;
  localparam int DW = 2 * CW + 1;
  localparam int RW = 3 * CW + FB + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = ~CMAX;

  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  logic signed [CW-1:0] q1 [4];
  logic signed [CW-1:0] q2 [4];

  assign q1[0] = in_first_real;
  assign q1[1] = in_first_i;
  assign q1[2] = in_first_j;
  assign q1[3] = in_first_k;
  assign q2[0] = in_second_real;
  assign q2[1] = in_second_i;
  assign q2[2] = in_second_j;
  assign q2[3] = in_second_k;

  qau_flags_t           fr_flags;
  logic signed [SW-1:0] fr_val [4];
  logic [RW-1:0]        fr_rem [4];
  logic [DW-1:0]        fr_div;

  qau_front #(.CW(CW), .FB(FB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (start && !busy_r),
    .kind_in   (kind_t'(in_kind)),
    .q1        (q1),
    .q2        (q2),
    .flags_out (fr_flags),
    .val_out   (fr_val),
    .rem_out   (fr_rem),
    .div_out   (fr_div)
  );

  logic [RW-1:0]        rem_c [CW+1][4];
  logic [CW-1:0]        q_c   [CW+1][4];
  logic [DW-1:0]        div_c [CW+1];
  qau_flags_t           fl_r  [CW];
  logic signed [SW-1:0] val_r [CW][4];

  assign rem_c[0] = fr_rem;
  assign div_c[0] = fr_div;
  assign q_c[0]   = '{default: '0};

  for (genvar s = 0; s < CW; s++) begin : g_cell
    qau_div_cell #(.CW(CW), .FB(FB), .SHIFT(CW - 1 - s)) u_cell (
      .clk     (clk),
      .rem_in  (rem_c[s]),
      .q_in    (q_c[s]),
      .div_in  (div_c[s]),
      .rem_out (rem_c[s+1]),
      .q_out   (q_c[s+1]),
      .div_out (div_c[s+1])
    );

    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fl_r[s] <= '0;
        end else begin
          fl_r[s] <= fr_flags;
        end
      end
      always_ff @(posedge clk) begin
        val_r[s] <= fr_val;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fl_r[s] <= '0;
        end else begin
          fl_r[s] <= fl_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        val_r[s] <= val_r[s-1];
      end
    end
  end

  qau_flags_t           fl;
  logic signed [CW:0]   sq   [4];
  logic signed [SW-1:0] cand [4];
  logic [CW-1:0]        res_nxt [4];
  logic [3:0]           ovl;

  always_comb begin
    fl = fl_r[CW-1];
    for (int i = 0; i < 4; i++) begin
      sq[i]   = fl.neg[i] ? -$signed({1'b0, q_c[CW][i]}) : $signed({1'b0, q_c[CW][i]});
      cand[i] = fl.is_div ? SW'(sq[i]) : val_r[CW-1][i];
      ovl[i]  = 1'b1;
      if (fl.is_div && fl.dbz) begin
        res_nxt[i] = '0;
        ovl[i]     = 1'b0;
      end else if (fl.is_div && fl.big[i]) begin
        res_nxt[i] = fl.neg[i] ? CMIN : CMAX;
      end else if (cand[i] > MAXV) begin
        res_nxt[i] = CMAX;
      end else if (cand[i] < MINV) begin
        res_nxt[i] = CMIN;
      end else begin
        res_nxt[i] = cand[i][CW-1:0];
        ovl[i]     = 1'b0;
      end
    end
  end

  logic          out_valid_r;
  logic          ovf_r;
  logic          dbz_r;
  logic [CW-1:0] res_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      dbz_r       <= 1'b0;
    end else begin
      out_valid_r <= fl.vld;
      ovf_r       <= fl.vld && (|ovl);
      dbz_r       <= fl.vld && fl.is_div && fl.dbz;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_real           = res_r[0];
  assign out_i              = res_r[1];
  assign out_j              = res_r[2];
  assign out_k              = res_r[3];
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dbz_r;

endmodule

@@ design/qau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks for the quaternion arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module qau_checker #(
  parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = qau_pkg::FRACTION_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        in_kind,
  input logic signed [COMPONENT_WIDTH-1:0] in_first_real,
  input logic signed [COMPONENT_WIDTH-1:0] in_first_i,
  input logic signed [COMPONENT_WIDTH-1:0] in_first_j,
  input logic signed [COMPONENT_WIDTH-1:0] in_first_k,
  input logic signed [COMPONENT_WIDTH-1:0] in_second_real,
  input logic signed [COMPONENT_WIDTH-1:0] in_second_i,
  input logic signed [COMPONENT_WIDTH-1:0] in_second_j,
  input logic signed [COMPONENT_WIDTH-1:0] in_second_k,
  input logic                              out_valid,
  input logic signed [COMPONENT_WIDTH-1:0] out_real,
  input logic signed [COMPONENT_WIDTH-1:0] out_i,
  input logic signed [COMPONENT_WIDTH-1:0] out_j,
  input logic signed [COMPONENT_WIDTH-1:0] out_k,
  input logic                              out_overflow,
  input logic                              out_divide_by_zero
);
  import qau_pkg::*;

  localparam int LAT = COMPONENT_WIDTH + 4;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted word");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_divide_by_zero |-> !out_overflow && out_valid)
    else $error("overflow with divide by zero");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_divide_by_zero |-> out_real == '0 && out_i == '0 && out_j == '0 && out_k == '0)
    else $error("nonzero result on divide by zero");

  a_dbz_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_divide_by_zero |-> $past(in_kind == KIND_DIV && in_second_real == '0 &&
      in_second_i == '0 && in_second_j == '0 && in_second_k == '0, LAT))
    else $error("divide by zero without zero divisor");

endmodule

bind quaternion_arithmetic_unit_top qau_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH),
  .FRACTION_BITS   (FRACTION_BITS)
) u_qau_checker (.*);

@@ tb/quaternion_arithmetic_unit_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_top_tb
// Drives add, subtract, Hamilton product and left quotient words through the
// quaternion unit with random start gaps, predicts each result with exact wide
// arithmetic and checks every strobed result in order.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_top_tb;
  import qau_pkg::*;

  typedef logic signed [15:0] comp_t;

  typedef struct {
    kind_t kind;
    comp_t a1, b1, c1, d1, a2, b2, c2, d2;
  } qop_t;

  typedef struct {
    comp_t r, i, j, k;
    logic  ovf, dbz;
  } qres_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  comp_t in_first_real = '0, in_first_i = '0, in_first_j = '0, in_first_k = '0;
  comp_t in_second_real = '0, in_second_i = '0, in_second_j = '0, in_second_k = '0;
  logic out_valid, out_overflow, out_divide_by_zero;
  comp_t out_real, out_i, out_j, out_k;

  qop_t  pending_ops[$];
  qres_t expected_results[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    words_sent = 0;
  int    cycle_count = 0;
  bit    drain_pause = 0;
  bit    quiet_stretch = 0;
  bit    stim_done = 0;

  quaternion_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind),
    .in_first_real(in_first_real), .in_first_i(in_first_i),
    .in_first_j(in_first_j), .in_first_k(in_first_k),
    .in_second_real(in_second_real), .in_second_i(in_second_i),
    .in_second_j(in_second_j), .in_second_k(in_second_k),
    .out_valid(out_valid), .out_real(out_real), .out_i(out_i),
    .out_j(out_j), .out_k(out_k),
    .out_overflow(out_overflow), .out_divide_by_zero(out_divide_by_zero)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic comp_t saturate(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -128'sd32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return comp_t'(v[15:0]);
  endfunction

  function automatic logic signed [127:0] quotient_tz(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
    logic signed [127:0] m;
    logic signed [127:0] q;
    m = (n < 0) ? -n : n;
    q = m / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic qres_t quat_predict(input qop_t op);
    logic signed [127:0] a1, b1, c1, d1, a2, b2, c2, d2, nrm;
    logic signed [127:0] w[4];
    qres_t res;
    a1 = op.a1; b1 = op.b1; c1 = op.c1; d1 = op.d1;
    a2 = op.a2; b2 = op.b2; c2 = op.c2; d2 = op.d2;
    res.ovf = 1'b0;
    res.dbz = 1'b0;
    case (op.kind)
      KIND_ADD: begin
        w[0] = a1 + a2; w[1] = b1 + b2; w[2] = c1 + c2; w[3] = d1 + d2;
      end
      KIND_SUB: begin
        w[0] = a1 - a2; w[1] = b1 - b2; w[2] = c1 - c2; w[3] = d1 - d2;
      end
      KIND_MUL: begin
        w[0] = (a1 * a2 - b1 * b2 - c1 * c2 - d1 * d2) >>> 8;
        w[1] = (a1 * b2 + b1 * a2 + c1 * d2 - d1 * c2) >>> 8;
        w[2] = (a1 * c2 - b1 * d2 + c1 * a2 + d1 * b2) >>> 8;
        w[3] = (a1 * d2 + b1 * c2 - c1 * b2 + d1 * a2) >>> 8;
      end
      default: begin
        nrm = a2 * a2 + b2 * b2 + c2 * c2 + d2 * d2;
        if (nrm == 0) begin
          res.dbz = 1'b1;
          for (int n = 0; n < 4; n++) w[n] = 0;
        end else begin
          w[0] = quotient_tz((a2 * a1 + b2 * b1 + c2 * c1 + d2 * d1) <<< 8, nrm);
          w[1] = quotient_tz((a2 * b1 - b2 * a1 - c2 * d1 + d2 * c1) <<< 8, nrm);
          w[2] = quotient_tz((a2 * c1 + b2 * d1 - c2 * a1 - d2 * b1) <<< 8, nrm);
          w[3] = quotient_tz((a2 * d1 - b2 * c1 + c2 * b1 - d2 * a1) <<< 8, nrm);
        end
      end
    endcase
    res.r = saturate(w[0], res.ovf);
    res.i = saturate(w[1], res.ovf);
    res.j = saturate(w[2], res.ovf);
    res.k = saturate(w[3], res.ovf);
    return res;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return comp_t'($urandom_range(0, 1) ? 16'sh0100 : 16'shff00);
      4, 5: return comp_t'($signed($urandom_range(0, 1023)) - 512);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic queue_op(input kind_t k, input comp_t a1, b1, c1, d1, a2, b2, c2, d2);
    qop_t op;
    op.kind = k;
    op.a1 = a1; op.b1 = b1; op.c1 = c1; op.d1 = d1;
    op.a2 = a2; op.b2 = b2; op.c2 = c2; op.d2 = d2;
    pending_ops.push_back(op);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (start && !busy) begin
      expected_results.push_back(quat_predict(qop_t'{kind_t'(in_kind),
        in_first_real, in_first_i, in_first_j, in_first_k,
        in_second_real, in_second_i, in_second_j, in_second_k}));
      words_sent <= words_sent + 1;
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if ((start && busy) || (!start && 0)) begin
      start <= 1'b1;
    end else if (pending_ops.size() != 0 && !drain_pause &&
                 (quiet_stretch || $urandom_range(0, 99) >= 27)) begin
      qop_t op;
      op = pending_ops.pop_front();
      start <= 1'b1;
      in_kind <= op.kind;
      in_first_real <= op.a1; in_first_i <= op.b1;
      in_first_j <= op.c1; in_first_k <= op.d1;
      in_second_real <= op.a2; in_second_i <= op.b2;
      in_second_j <= op.c2; in_second_k <= op.d2;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      qres_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_real !== want.r) report_mismatch("real", out_real, want.r);
        if (out_i !== want.i) report_mismatch("i", out_i, want.i);
        if (out_j !== want.j) report_mismatch("j", out_j, want.j);
        if (out_k !== want.k) report_mismatch("k", out_k, want.k);
        if (out_overflow !== want.ovf) report_mismatch("overflow", out_overflow, want.ovf);
        if (out_divide_by_zero !== want.dbz)
          report_mismatch("divide_by_zero", out_divide_by_zero, want.dbz);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("quaternion_arithmetic_unit_top_tb failed");
      $finish;
    end
  end

  initial begin
    kind_t k;
    for (int n = 0; n < 4; n++) begin
      k = kind_t'(n);
      queue_op(k, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      queue_op(k, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
               16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      queue_op(k, 16'sh0180, -16'sh0040, 16'sh0200, 16'sh0001,
               16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
      queue_op(k, 16'sh8000, 16'sh7fff, 16'sh0000, -16'sh0001,
               -16'sh0001, 16'sh0003, 16'sh8000, 16'sh7fff);
    end
    queue_op(KIND_DIV, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 0, 0, 0, 0);
    queue_op(KIND_DIV, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 0, 0, 0, 16'sh0001);
    queue_op(KIND_DIV, -16'sh0003, 16'sh0001, 16'sh0000, 16'sh0000,
             16'sh0002, 0, 0, 0);
    queue_op(KIND_MUL, -16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0);
    queue_op(KIND_MUL, 0, 16'sh0100, 0, 0, 0, 0, 16'sh0100, 0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // refill after reset; words queued above wait for rst_n
    for (int n = 0; n < 800; n++) begin
      queue_op(kind_t'($urandom_range(0, 3)), rand_comp(), rand_comp(), rand_comp(),
               rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if (n == 400) begin
        while (pending_ops.size() != 0) @(posedge clk);
        drain_pause = 1;
        while (expected_results.size() != 0 || start) @(posedge clk);
        drain_pause = 0;
        quiet_stretch = 1;
      end
    end
    while (pending_ops.size() > 250) @(posedge clk);
    quiet_stretch = 0;
    while (pending_ops.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d words sent, %0d results checked over all four operations,",
             words_sent, results_seen);
    $display("saturation, zero divisor and one drained pause included");
    if (mismatches == 0) begin
      $display("quaternion_arithmetic_unit_top_tb passed");
    end else begin
      $display("quaternion_arithmetic_unit_top_tb failed");
    end
    $finish;
  end

endmodule
